// ===== src/icdf_pkg.sv =====
package icdf_pkg;

  // width of the entry count register and of the search bounds
  localparam int unsigned CNT_W = 11;
  // width of the halving step counter
  localparam int unsigned STEP_W = 4;
  // fixed payload widths
  localparam int unsigned IDX_W = 10;
  localparam int unsigned PROB_W = 16;
  localparam int unsigned UNI_W = 16;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 16;

  // defaults for the top level parameters
  localparam int unsigned DEF_MAX_ENTRIES = 1024;
  localparam int unsigned DEF_PROB_BITS = 16;

  // reset value of the entry count register
  localparam logic [CNT_W-1:0] ACTIVE_RESET = 11'd1024;

  // item kinds carried on tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // search bounds and current midpoint
  typedef struct packed {
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [CNT_W-1:0] mid;
  } bounds_t;

  // number of halving steps: bit length of the entry count
  function automatic logic [STEP_W-1:0] bit_len(input logic [CNT_W-1:0] n);
    logic [STEP_W-1:0] len;
    len = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (n[i]) len = STEP_W'(i + 1);
    end
    return len;
  endfunction

endpackage

// ===== src/inverse_cdf_index_sampler_unit.sv =====
// channel   | dir | handshake                  | payload
// s_axis    | in  | s_axis_tvalid/tready       | tdata: entry_index, prob_value, uniform_value;
//           |     |                            | tuser: kind; tlast: last_in_batch
// m_axis    | out | m_axis_tvalid/tready       | tdata: drawn_index; tlast: batch_end
// cfg       | in  | cfg_valid_i/cfg_ready_o    | cfg_data_i: active_entries
//
// a load gives no word. a draw issues the first table read when it is accepted, makes
// its halving steps through the single table read port and shared compare unit, then
// hands over the result. the search loop is one table read plus one compare per cycle.
// rst_ni clears control state, the running total and the entry count (to 1024);
// table contents are undefined until loaded. a stalled output holds the result,
// and the next item is accepted while that word waits.
module inverse_cdf_index_sampler_unit #(
  parameter int unsigned MAX_ENTRIES = icdf_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned PROB_BITS   = icdf_pkg::DEF_PROB_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] entry_index, [25:10] prob_value, [41:26] uniform_value, [47:42] zero
  input  logic [icdf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] kind
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [9:0] drawn_index, [15:10] zero
  output logic [icdf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [icdf_pkg::CNT_W-1:0]        cfg_data_i
);

  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CUM_W = PROB_BITS + AW;
  localparam int unsigned CW    = icdf_pkg::CNT_W;
  localparam logic [63:0] ProbMaskWide = (64'd1 << PROB_BITS) - 64'd1;
  localparam logic [icdf_pkg::PROB_W-1:0] ProbMask = icdf_pkg::PROB_W'(ProbMaskWide);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [CW-1:0]                   active_q;
  logic [CW-1:0]                   n_eff;
  logic [CUM_W-1:0]                total_q, total_d;
  icdf_pkg::bounds_t               bnd_q, bnd_d, bnd_nxt;
  logic [icdf_pkg::STEP_W-1:0]     steps_q, steps_d;
  logic [icdf_pkg::UNI_W-1:0]      uni_q, uni_d;
  logic                            last_q, last_d;
  logic                            out_valid_q, out_valid_d;
  logic [icdf_pkg::IDX_W-1:0]      out_idx_q, out_idx_d;
  logic                            out_last_q, out_last_d;

  logic                            in_acc;
  logic [icdf_pkg::IDX_W-1:0]      in_idx;
  logic [icdf_pkg::PROB_W-1:0]     in_prob;
  logic [icdf_pkg::UNI_W-1:0]      in_uni;
  logic                            idx_ok;
  logic [CUM_W-1:0]                base;
  logic [CUM_W:0]                  sum;
  logic                            tbl_we;
  logic [AW-1:0]                   tbl_waddr;
  logic [AW-1:0]                   tbl_raddr;
  logic [CUM_W-1:0]                tbl_rdata;
  logic [CW-1:0]                   rd_mid;
  logic                            slot_free;

  // payload unpacking
  assign in_idx  = s_axis_tdata[9:0];
  assign in_prob = s_axis_tdata[25:10] & ProbMask;
  assign in_uni  = s_axis_tdata[41:26];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= icdf_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  // effective entry count: zero reads as one, clamp to table depth
  always_comb begin
    if (active_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(active_q) > MAX_ENTRIES) begin
      n_eff = CW'(MAX_ENTRIES);
    end else begin
      n_eff = active_q;
    end
  end

  // load path: store total before the weight, then add with saturation
  assign idx_ok    = (32'(in_idx) < MAX_ENTRIES);
  assign base      = (in_idx == '0) ? '0 : total_q;
  assign sum       = {1'b0, base} + (CUM_W + 1)'({{CUM_W{1'b0}}, in_prob});
  assign tbl_we    = in_acc && (s_axis_tuser == icdf_pkg::KIND_LOAD) && idx_ok;
  assign tbl_waddr = AW'({{AW{1'b0}}, in_idx});

  always_comb begin
    total_d = total_q;
    if (tbl_we) begin
      total_d = sum[CUM_W] ? '1 : sum[CUM_W-1:0];
    end
  end

  // shared halving step
  icdf_step #(
    .CUM_W (CUM_W)
  ) u_step (
    .cur_i (bnd_q),
    .cdf_i (tbl_rdata),
    .uni_i (uni_q),
    .nxt_o (bnd_nxt)
  );

  // read address: first midpoint when idle, next midpoint while searching
  assign rd_mid    = (state_q == ST_IDLE) ? (n_eff >> 1) : bnd_nxt.mid;
  assign tbl_raddr = AW'({{AW{1'b0}}, rd_mid});

  icdf_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW),
    .CUM_W (CUM_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (base),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  assign slot_free = !out_valid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d     = state_q;
    bnd_d       = bnd_q;
    steps_d     = steps_q;
    uni_d       = uni_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == icdf_pkg::KIND_DRAW)) begin
          bnd_d.lo  = '0;
          bnd_d.hi  = n_eff;
          bnd_d.mid = n_eff >> 1;
          steps_d   = icdf_pkg::bit_len(n_eff);
          uni_d     = in_uni;
          last_d    = s_axis_tlast;
          state_d   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        bnd_d   = bnd_nxt;
        steps_d = steps_q - 1'b1;
        if (steps_q == icdf_pkg::STEP_W'(1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = bnd_q.lo[icdf_pkg::IDX_W-1:0];
          out_last_d  = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bnd_q      <= bnd_d;
    uni_q      <= uni_d;
    last_q     <= last_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = icdf_pkg::OUT_DATA_W'(out_idx_q);
  assign m_axis_tlast  = out_last_q;

  // search range never collapses
  a_range_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (bnd_q.lo < bnd_q.hi))
    else $error("search range empty");

  // step counter live while searching
  a_steps_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (steps_q != '0))
    else $error("search with no steps left");

  // a draw starts a search
  a_draw_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser == icdf_pkg::KIND_DRAW)) |=> (state_q == ST_SEARCH))
    else $error("draw did not start search");

  // result lies below the entry count
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (CW'(out_idx_q) < n_eff))
    else $error("drawn index out of range");

endmodule

// ===== src/icdf_table.sv =====
module icdf_table #(
  parameter int unsigned DEPTH = icdf_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned AW    = $clog2(icdf_pkg::DEF_MAX_ENTRIES),
  parameter int unsigned CUM_W = icdf_pkg::DEF_PROB_BITS + $clog2(icdf_pkg::DEF_MAX_ENTRIES)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [CUM_W-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [CUM_W-1:0] rdata_o
);

  logic [CUM_W-1:0] mem_q [DEPTH];
  logic [CUM_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, read every cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/icdf_step.sv =====
module icdf_step #(
  parameter int unsigned CUM_W = icdf_pkg::DEF_PROB_BITS + $clog2(icdf_pkg::DEF_MAX_ENTRIES)
) (
  input  icdf_pkg::bounds_t                cur_i,
  input  logic [CUM_W-1:0]                 cdf_i,
  input  logic [icdf_pkg::UNI_W-1:0]       uni_i,
  output icdf_pkg::bounds_t                nxt_o
);

  localparam int unsigned CMP_W = CUM_W + icdf_pkg::UNI_W;

  logic [CMP_W-1:0]             cdf_ext;
  logic [CMP_W-1:0]             uni_ext;
  logic                         move_lo;
  logic [icdf_pkg::CNT_W:0]     sum;

  // compare cumulative value at the midpoint with the fraction
  assign cdf_ext = CMP_W'(cdf_i);
  assign uni_ext = CMP_W'(uni_i);
  assign move_lo = (cdf_ext <= uni_ext);

  // halve the range and form the next midpoint
  always_comb begin
    nxt_o.lo  = move_lo ? cur_i.mid : cur_i.lo;
    nxt_o.hi  = move_lo ? cur_i.hi : cur_i.mid;
    sum       = {1'b0, nxt_o.lo} + {1'b0, nxt_o.hi};
    nxt_o.mid = sum[icdf_pkg::CNT_W:1];
  end

endmodule
